/* sv/escpwm_pkg.sv */
// ----------------------------------------------------------------------------
// escpwm_pkg
// Shared types and constants for the four-channel ESC PWM unit.
// ----------------------------------------------------------------------------
`default_nettype none

package escpwm_pkg;

   localparam int unsigned DATA_W  = 16;
   localparam int unsigned MOTOR_W = 2;
   localparam int unsigned PWM_W   = 4;
   localparam int unsigned CSR_W   = 2;

   localparam logic [DATA_W-1:0] RESET_DIVISOR  = 16'd71;
   localparam logic [DATA_W-1:0] RESET_TOP      = 16'd5000;
   localparam logic [DATA_W-1:0] RESET_LIMIT    = 16'd2100;
   localparam logic [DATA_W-1:0] RESET_SAFE     = 16'd1000;
   localparam logic [DATA_W-1:0] RESET_POWER    = 16'd1000;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_ASSIGN = 2'd1,
      OP_APPLY  = 2'd2,
      OP_STOP   = 2'd3
   } op_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_DIVISOR = 2'd0,
      CSR_TOP     = 2'd1,
      CSR_LIMIT   = 2'd2,
      CSR_SAFE    = 2'd3
   } csr_type;

   typedef struct packed {
      logic              wrap;
      logic [DATA_W-1:0] count_next;
   } tb_type;

endpackage

`default_nettype wire

/* sv/four_channel_esc_pwm_unit.sv */
// ----------------------------------------------------------------------------
// four_channel_esc_pwm_unit
// Four-channel PWM generator for motor speed controllers.
//
// Items arrive on the req_ channel (operation, motor index, power) and each
// one yields exactly one rsp_ item: the four PWM outputs and the stored power
// of the addressed motor, both as they stand after the item. A tick item
// steps the prescaler and main counter; assign, apply and stop manage the
// stored, preload and active compare values. Registers are written on the
// csr_ port, one per cycle, with no read-back.
// An item is registered at acceptance, processed once the result register
// is free or being read, and its result is held in the output register. One
// item is taken every cycle while the receiver does not stall.
// Reset loads the register defaults and 1000 into every compare and clears
// both counters. When the receiver stalls, the result register holds and
// the input register still takes one more item; further items wait.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_esc_pwm_unit #(
   parameter int CHANNELS = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_operation,
   input  wire logic [escpwm_pkg::MOTOR_W-1:0] req_motor_index,
   input  wire logic [escpwm_pkg::DATA_W-1:0]  req_power_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [escpwm_pkg::PWM_W-1:0]        rsp_pwm_outputs,
   output logic [escpwm_pkg::DATA_W-1:0]       rsp_stored_power,
   input  wire logic                           csr_write_enable,
   input  wire logic [escpwm_pkg::CSR_W-1:0]   csr_index,
   input  wire logic [escpwm_pkg::DATA_W-1:0]  csr_write_data
);

   logic [escpwm_pkg::DATA_W-1:0] divisor_ff, top_ff, limit_ff, safe_ff;

   logic                           in_valid_ff;
   escpwm_pkg::op_type             in_op_ff;
   logic [escpwm_pkg::MOTOR_W-1:0] in_motor_ff;
   logic [escpwm_pkg::DATA_W-1:0]  in_power_ff;

   logic                           out_valid_ff;
   logic [escpwm_pkg::PWM_W-1:0]   out_pwm_ff;
   logic [escpwm_pkg::DATA_W-1:0]  out_power_ff;

   logic                           step;
   logic                           accept;
   escpwm_pkg::tb_type             tb;
   logic [escpwm_pkg::PWM_W-1:0]   pwm;
   logic [escpwm_pkg::DATA_W-1:0]  readback;

   assign step      = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | step;
   assign accept    = req_valid & req_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_pwm_outputs  = out_pwm_ff;
   assign rsp_stored_power = out_power_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= escpwm_pkg::RESET_DIVISOR;
         top_ff     <= escpwm_pkg::RESET_TOP;
         limit_ff   <= escpwm_pkg::RESET_LIMIT;
         safe_ff    <= escpwm_pkg::RESET_SAFE;
      end else if (csr_write_enable) begin
         case (escpwm_pkg::csr_type'(csr_index))
            escpwm_pkg::CSR_DIVISOR: divisor_ff <= csr_write_data;
            escpwm_pkg::CSR_TOP:     top_ff     <= csr_write_data;
            escpwm_pkg::CSR_LIMIT:   limit_ff   <= csr_write_data;
            escpwm_pkg::CSR_SAFE:    safe_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff    <= escpwm_pkg::op_type'(req_operation);
         in_motor_ff <= req_motor_index;
         in_power_ff <= req_power_value;
      end
   end

   escpwm_timebase u_timebase (
      .clock   (clock),
      .reset   (reset),
      .tick    (step && in_op_ff == escpwm_pkg::OP_TICK),
      .divisor (divisor_ff),
      .top     (top_ff),
      .tb      (tb)
   );

   escpwm_channels #(
      .CHANNELS (CHANNELS)
   ) u_channels (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .op       (in_op_ff),
      .motor    (in_motor_ff),
      .power    (in_power_ff),
      .limit    (limit_ff),
      .safe     (safe_ff),
      .tb       (tb),
      .pwm      (pwm),
      .readback (readback)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (~out_valid_ff | rsp_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_pwm_ff   <= pwm;
         out_power_ff <= readback;
      end
   end

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed item did not reach the result register");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled while result register empty");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff)
      else $error("pending item dropped during stall");

   a_wrap_only_on_step: assert property (@(posedge clock) disable iff (reset)
      tb.wrap |-> step)
      else $error("counter wrapped without an item");

endmodule

`default_nettype wire

/* sv/escpwm_timebase.sv */
// ----------------------------------------------------------------------------
// escpwm_timebase
// Prescaler and up-counting main counter with wrap detection.
// ----------------------------------------------------------------------------
`default_nettype none

module escpwm_timebase (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          tick,
   input  wire logic [escpwm_pkg::DATA_W-1:0] divisor,
   input  wire logic [escpwm_pkg::DATA_W-1:0] top,
   output escpwm_pkg::tb_type                 tb
);

   logic [escpwm_pkg::DATA_W-1:0] prescale_ff, prescale_in;
   logic [escpwm_pkg::DATA_W-1:0] main_ff, main_in;
   logic                          expire;
   logic                          at_top;

   always_comb begin
      expire      = prescale_ff >= divisor;
      at_top      = main_ff >= top;
      prescale_in = prescale_ff;
      main_in     = main_ff;
      if (tick) begin
         if (expire) begin
            prescale_in = '0;
            main_in     = at_top ? '0 : main_ff + 1'b1;
         end else begin
            prescale_in = prescale_ff + 1'b1;
         end
      end
      tb.wrap       = tick & expire & at_top;
      tb.count_next = main_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         main_ff     <= '0;
      end else begin
         prescale_ff <= prescale_in;
         main_ff     <= main_in;
      end
   end

endmodule

`default_nettype wire

/* sv/escpwm_channels.sv */
// ----------------------------------------------------------------------------
// escpwm_channels
// Stored, preload and active compare registers and output compare.
// ----------------------------------------------------------------------------
`default_nettype none

module escpwm_channels #(
   parameter int CHANNELS = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire escpwm_pkg::op_type             op,
   input  wire logic [escpwm_pkg::MOTOR_W-1:0] motor,
   input  wire logic [escpwm_pkg::DATA_W-1:0]  power,
   input  wire logic [escpwm_pkg::DATA_W-1:0]  limit,
   input  wire logic [escpwm_pkg::DATA_W-1:0]  safe,
   input  wire escpwm_pkg::tb_type             tb,
   output logic [escpwm_pkg::PWM_W-1:0]        pwm,
   output logic [escpwm_pkg::DATA_W-1:0]       readback
);

   logic [escpwm_pkg::DATA_W-1:0] stored_ff  [CHANNELS];
   logic [escpwm_pkg::DATA_W-1:0] stored_in  [CHANNELS];
   logic [escpwm_pkg::DATA_W-1:0] preload_ff [CHANNELS];
   logic [escpwm_pkg::DATA_W-1:0] preload_in [CHANNELS];
   logic [escpwm_pkg::DATA_W-1:0] active_ff  [CHANNELS];
   logic [escpwm_pkg::DATA_W-1:0] active_in  [CHANNELS];
   logic [escpwm_pkg::DATA_W-1:0] clamped;

   always_comb begin
      clamped  = (power > limit) ? safe : power;
      pwm      = '0;
      readback = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         stored_in[i]  = stored_ff[i];
         preload_in[i] = preload_ff[i];
         active_in[i]  = tb.wrap ? preload_ff[i] : active_ff[i];
         if (step && op == escpwm_pkg::OP_ASSIGN && 32'(motor) == i) begin
            stored_in[i] = clamped;
         end
         if (step && op == escpwm_pkg::OP_APPLY) begin
            preload_in[i] = stored_ff[i];
         end
         if (step && op == escpwm_pkg::OP_STOP) begin
            preload_in[i] = safe;
         end
         if (32'(motor) == i) begin
            readback = stored_in[i];
         end
      end
      for (int i = 0; i < CHANNELS && i < int'(escpwm_pkg::PWM_W); i++) begin
         pwm[i] = tb.count_next < active_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            stored_ff[i]  <= escpwm_pkg::RESET_POWER;
            preload_ff[i] <= escpwm_pkg::RESET_POWER;
            active_ff[i]  <= escpwm_pkg::RESET_POWER;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            stored_ff[i]  <= stored_in[i];
            preload_ff[i] <= preload_in[i];
            active_ff[i]  <= active_in[i];
         end
      end
   end

endmodule

`default_nettype wire
